@@ sv/tlik_pkg.sv @@
// ----------------------------------------------------------------------------
// tlik_pkg: shared types and constants
// Fixed-point widths, angle constants and the CORDIC arctangent table for
// the two-link planar inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

	localparam int COORD_W  = 16;   // x_pos, y_pos, link lengths
	localparam int R2_W     = 32;   // x^2 + y^2
	localparam int COS_W    = 18;   // law-of-cosines argument, Q.16 in [-1, 1]
	localparam int CORDIC_W = 28;   // CORDIC x/y datapath
	localparam int ANG_W    = 20;   // CORDIC angle accumulator, Q.16 radians
	localparam int SH_W     = 17;
	localparam int EL_W     = 15;

	localparam int ATAN_LEN = 24;

	localparam logic signed [ANG_W-1:0] PI_Q16      = 20'sd205887;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102943;
	localparam logic signed [COS_W-1:0] ONE_Q16     = 18'sd65536;
	localparam logic        [EL_W-1:0]  ELBOW_MAX   = 15'd25736;
	localparam logic signed [SH_W-1:0]  SHOULDER_MIN = -17'sd65535 - 17'sd1;
	localparam logic signed [SH_W-1:0]  SHOULDER_MAX = 17'sd65535;

	// atan(2^-i) in Q.16, rounded to nearest.
	function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
		logic signed [ANG_W-1:0] a;
		unique case (i)
			0: a = 20'sd51472;
			1: a = 20'sd30385;
			2: a = 20'sd16055;
			3: a = 20'sd8150;
			4: a = 20'sd4091;
			5: a = 20'sd2047;
			6: a = 20'sd1024;
			7: a = 20'sd512;
			8: a = 20'sd256;
			9: a = 20'sd128;
			10: a = 20'sd64;
			11: a = 20'sd32;
			12: a = 20'sd16;
			13: a = 20'sd8;
			14: a = 20'sd4;
			15: a = 20'sd2;
			16: a = 20'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

@@ sv/tlik_isqrt.sv @@
// ----------------------------------------------------------------------------
// tlik_isqrt: pipelined integer square root
// Floor square root of an IW-bit radicand, one result bit per stage, with a
// side channel that travels alongside the data.
// ----------------------------------------------------------------------------
module tlik_isqrt #(
	parameter int IW = 48,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_i,
	input  logic [IW-1:0]    rad_i,
	input  logic [SW-1:0]    side_i,
	output logic             valid_o,
	output logic [IW/2-1:0]  root_o,
	output logic [SW-1:0]    side_o
);

	localparam int OW = IW / 2;
	localparam int RW = OW + 3;

	logic          v_s    [0:OW];
	logic [OW-1:0] root_s [0:OW];
	logic [RW-1:0] rem_s  [0:OW];
	logic [IW-1:0] rad_s  [0:OW];
	logic [SW-1:0] side_s [0:OW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_s[0] <= '0;
			rem_s[0]  <= '0;
			rad_s[0]  <= rad_i;
			side_s[0] <= side_i;
		end
	end

	for (genvar k = 0; k < OW; k++) begin : g_step
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic          ge;

		// Bring down the next two radicand bits and try root*4 + 1.
		always_comb begin
			rem_sh = {rem_s[k][RW-3:0], rad_s[k][IW-1:IW-2]};
			trial  = {1'b0, root_s[k], 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k+1] <= {root_s[k][OW-2:0], ge};
				rad_s[k+1]  <= {rad_s[k][IW-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign valid_o = v_s[OW];
	assign root_o  = root_s[OW];
	assign side_o  = side_s[OW];

endmodule

@@ sv/tlik_div.sv @@
// ----------------------------------------------------------------------------
// tlik_div: pipelined clamped quotient
// Forms num/den in Q.16, clamped to [-1, 1] and truncated toward zero, with a
// restoring divider that settles one quotient bit per stage.
// ----------------------------------------------------------------------------
module tlik_div #(
	parameter int NW = 44,
	parameter int DW = 42,
	parameter int SW = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_i,
	input  logic signed [NW-1:0]              num_i,
	input  logic        [DW-1:0]              den_i,
	input  logic        [SW-1:0]              side_i,
	output logic                              valid_o,
	output logic signed [tlik_pkg::COS_W-1:0] c_o,
	output logic        [SW-1:0]              side_o
);

	localparam int QW = tlik_pkg::COS_W - 2;
	localparam int RW = DW + 1;

	// Input registers.
	logic                 v_s0;
	logic signed [NW-1:0] num_s0;
	logic [DW-1:0]        den_s0;
	logic [SW-1:0]        side_s0;

	logic          v_s    [0:QW];
	logic [RW-1:0] rem_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [QW-1:0] q_s    [0:QW];
	logic          pos_s  [0:QW];
	logic          neg_s  [0:QW];
	logic          sgn_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];

	logic signed [NW-1:0] den_x;
	logic signed [NW-1:0] mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0   <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s0   <= valid_i;
			v_s[0] <= v_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s0  <= num_i;
			den_s0  <= den_i;
			side_s0 <= side_i;
		end
	end

	// Clamp decisions; the magnitude only matters when neither clamp hits.
	always_comb begin
		den_x = signed'({{(NW-DW){1'b0}}, den_s0});
		mag   = num_s0[NW-1] ? -num_s0 : num_s0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s[0]  <= num_s0 >= den_x;
			neg_s[0]  <= num_s0 <= -den_x;
			sgn_s[0]  <= num_s0[NW-1];
			rem_s[0]  <= mag[RW-1:0];
			den_s[0]  <= den_s0;
			q_s[0]    <= '0;
			side_s[0] <= side_s0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0] rem2;
		logic          ge;

		always_comb begin
			rem2 = {rem_s[k][RW-2:0], 1'b0};
			ge   = rem2 >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (rem2 - {1'b0, den_s[k]}) : rem2;
				q_s[k+1]    <= {q_s[k][QW-2:0], ge};
				den_s[k+1]  <= den_s[k];
				pos_s[k+1]  <= pos_s[k];
				neg_s[k+1]  <= neg_s[k];
				sgn_s[k+1]  <= sgn_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	logic signed [tlik_pkg::COS_W-1:0] q_x;

	always_comb begin
		q_x = signed'({2'b00, q_s[QW]});
		priority if (pos_s[QW]) begin
			c_o = tlik_pkg::ONE_Q16;
		end else if (neg_s[QW]) begin
			c_o = -tlik_pkg::ONE_Q16;
		end else if (sgn_s[QW]) begin
			c_o = -q_x;
		end else begin
			c_o = q_x;
		end
	end

	assign valid_o = v_s[QW];
	assign side_o  = side_s[QW];

endmodule

@@ sv/tlik_cordic.sv @@
// ----------------------------------------------------------------------------
// tlik_cordic: pipelined vectoring CORDIC
// Returns the angle of (x, y) in Q.16 radians. A quarter-turn prerotation
// brings the left half plane into range, then one micro-rotation per stage.
// ----------------------------------------------------------------------------
module tlik_cordic #(
	parameter int N = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 valid_i,
	input  logic signed [tlik_pkg::CORDIC_W-1:0] x_i,
	input  logic signed [tlik_pkg::CORDIC_W-1:0] y_i,
	output logic                                 valid_o,
	output logic signed [tlik_pkg::ANG_W-1:0]    z_o
);

	localparam int W  = tlik_pkg::CORDIC_W;
	localparam int AW = tlik_pkg::ANG_W;

	logic                 v_s [0:N];
	logic signed [W-1:0]  x_s [0:N];
	logic signed [W-1:0]  y_s [0:N];
	logic signed [AW-1:0] z_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (x_i >= 0) begin
				x_s[0] <= x_i;
				y_s[0] <= y_i;
				z_s[0] <= '0;
			end else if (y_i >= 0) begin
				x_s[0] <= y_i;
				y_s[0] <= -x_i;
				z_s[0] <= tlik_pkg::HALF_PI_Q16;
			end else begin
				x_s[0] <= -y_i;
				y_s[0] <= x_i;
				z_s[0] <= -tlik_pkg::HALF_PI_Q16;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [W-1:0] xs;
		logic signed [W-1:0] ys;

		always_comb begin
			xs = x_s[i] >>> i;
			ys = y_s[i] >>> i;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		// Rotate toward the x axis; the sign of y picks the direction.
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + tlik_pkg::atan_q16(i);
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - tlik_pkg::atan_q16(i);
				end
			end
		end
	end

	assign valid_o = v_s[N];
	assign z_o     = z_s[N];

endmodule

@@ sv/two_link_planar_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// two_link_planar_inverse_kinematics: joint angles for a two-link planar arm
// Takes one target point (x_pos, y_pos, signed Q8.8) per clock while the
// output is not stalled and returns the shoulder and elbow angles in
// radians with 13 fractional bits. The pipeline is a square root for the
// reach, two 16-step restoring dividers for the law-of-cosines arguments,
// two more square roots for the sines and three parallel vectoring CORDICs
// for the bearing and the two arccosines; every stage takes a new request
// each cycle unless the output stalls. A stalled output holds the whole
// pipeline. Targets at the origin or beyond the sum of the link lengths
// give zero angles with out_of_reach set. Link lengths are written through
// the APB port at byte addresses 0 and 4; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module two_link_planar_inverse_kinematics #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// Target requests
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  x_pos,
	input  logic signed [15:0]  y_pos,
	// Angle results
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [16:0]  shoulder_angle,
	output logic [14:0]         elbow_angle,
	output logic                out_of_reach
);

	localparam int CW    = tlik_pkg::COORD_W;
	localparam int CSW   = tlik_pkg::COS_W;
	localparam int AW    = tlik_pkg::ANG_W;
	localparam int XW    = tlik_pkg::CORDIC_W;
	localparam int NUM_W = 44;
	localparam int DEN_W = 42;

	// ---------------- configuration ----------------
	logic [CW-1:0] upper_q;
	logic [CW-1:0] lower_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 16'd2560;
			lower_q <= 16'd1792;
		end else if (wr_en) begin
			if (paddr[2]) begin
				lower_q <= pwdata[CW-1:0];
			end else begin
				upper_q <= pwdata[CW-1:0];
			end
		end
	end

	assign prdata = paddr[2] ? {16'b0, lower_q} : {16'b0, upper_q};

	// Products of the link lengths, refreshed every cycle.
	logic [31:0] l1sq_q;
	logic [31:0] l2sq_q;
	logic [33:0] reach_q;
	logic [32:0] den2_q;
	logic [16:0] lsum;

	assign lsum = {1'b0, upper_q} + {1'b0, lower_q};

	always_ff @(posedge clk) begin
		l1sq_q  <= 32'(upper_q) * 32'(upper_q);
		l2sq_q  <= 32'(lower_q) * 32'(lower_q);
		reach_q <= 34'(lsum) * 34'(lsum);
		den2_q  <= (33'(upper_q) * 33'(lower_q)) << 1;
	end

	// ---------------- flow control ----------------
	logic out_valid_q;
	logic en;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// ---------------- stages 1 and 2: squares ----------------
	logic                 v_s1;
	logic signed [CW-1:0] x_s1;
	logic signed [CW-1:0] y_s1;
	logic                 v_s2;
	logic signed [CW-1:0] x_s2;
	logic signed [CW-1:0] y_s2;
	logic [31:0]          xx_s2;
	logic [31:0]          yy_s2;
	logic                 zero_s2;
	logic signed [31:0]   xx;
	logic signed [31:0]   yy;

	assign xx = 32'(x_s1) * 32'(x_s1);
	assign yy = 32'(y_s1) * 32'(y_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_pos;
			y_s1    <= y_pos;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			xx_s2   <= unsigned'(xx);
			yy_s2   <= unsigned'(yy);
			zero_s2 <= (x_s1 == 16'sd0) && (y_s1 == 16'sd0);
		end
	end

	// ---------------- reach: sqrt(r^2) in Q.16 ----------------
	localparam int SQ1_SW = 2 * CW + 32 + 1;

	logic [31:0]        r2;
	logic               oor;
	logic               sq1_v;
	logic [23:0]        r_q16;
	logic [SQ1_SW-1:0]  sq1_side;
	logic signed [CW-1:0] x_a;
	logic signed [CW-1:0] y_a;
	logic [31:0]        r2_a;
	logic               oor_a;

	assign r2  = xx_s2 + yy_s2;
	assign oor = zero_s2 || ({2'b00, r2} > reach_q);

	tlik_isqrt #(
		.IW (48),
		.SW (SQ1_SW)
	) u_sqrt_reach (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (v_s2),
		.rad_i   ({r2, 16'b0}),
		.side_i  ({x_s2, y_s2, r2, oor}),
		.valid_o (sq1_v),
		.root_o  (r_q16),
		.side_o  (sq1_side)
	);

	assign {x_a, y_a, r2_a, oor_a} = sq1_side;

	// ---------------- law-of-cosines arguments ----------------
	logic signed [NUM_W-1:0] num1;
	logic signed [NUM_W-1:0] num2;
	logic [39:0]             l1r;
	logic [DEN_W-1:0]        den1;

	always_comb begin
		num1 = (signed'({12'b0, l1sq_q}) + signed'({12'b0, r2_a})
			- signed'({12'b0, l2sq_q})) <<< 8;
		num2 = signed'({12'b0, l1sq_q}) + signed'({12'b0, l2sq_q})
			- signed'({12'b0, r2_a});
		l1r  = 40'(upper_q) * 40'(r_q16);
		den1 = {1'b0, l1r, 1'b0};
	end

	logic                 div1_v;
	logic                 div2_v;
	logic signed [CSW-1:0] c1;
	logic signed [CSW-1:0] c2;
	logic [2*CW-1:0]      div1_side;
	logic                 oor_b;
	logic signed [CW-1:0] x_b;
	logic signed [CW-1:0] y_b;

	tlik_div #(
		.NW (NUM_W),
		.DW (DEN_W),
		.SW (2 * CW)
	) u_div_shoulder (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq1_v),
		.num_i   (num1),
		.den_i   (den1),
		.side_i  ({x_a, y_a}),
		.valid_o (div1_v),
		.c_o     (c1),
		.side_o  (div1_side)
	);

	tlik_div #(
		.NW (NUM_W),
		.DW (DEN_W),
		.SW (1)
	) u_div_elbow (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq1_v),
		.num_i   (num2),
		.den_i   ({9'b0, den2_q}),
		.side_i  (oor_a),
		.valid_o (div2_v),
		.c_o     (c2),
		.side_o  (oor_b)
	);

	assign {x_b, y_b} = div1_side;

	// ---------------- sines: sqrt(1 - c^2) ----------------
	logic signed [35:0] csq1;
	logic signed [35:0] csq2;
	logic [33:0]        rad1;
	logic [33:0]        rad2;

	always_comb begin
		csq1 = 36'(c1) * 36'(c1);
		csq2 = 36'(c2) * 36'(c2);
		rad1 = 34'h1_0000_0000 - unsigned'(csq1[33:0]);
		rad2 = 34'h1_0000_0000 - unsigned'(csq2[33:0]);
	end

	localparam int SQ2_SW = 2 * CW + CSW;

	logic               sq2_v;
	logic               sq3_v;
	logic [16:0]        s1;
	logic [16:0]        s2;
	logic [SQ2_SW-1:0]  sq2_side;
	logic [CSW:0]       sq3_side;
	logic signed [CW-1:0]  x_c;
	logic signed [CW-1:0]  y_c;
	logic signed [CSW-1:0] c1_c;
	logic signed [CSW-1:0] c2_c;
	logic                  oor_c;

	tlik_isqrt #(
		.IW (34),
		.SW (SQ2_SW)
	) u_sqrt_sin1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (div1_v && div2_v),
		.rad_i   (rad1),
		.side_i  ({x_b, y_b, c1}),
		.valid_o (sq2_v),
		.root_o  (s1),
		.side_o  (sq2_side)
	);

	tlik_isqrt #(
		.IW (34),
		.SW (CSW + 1)
	) u_sqrt_sin2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (div1_v && div2_v),
		.rad_i   (rad2),
		.side_i  ({c2, oor_b}),
		.valid_o (sq3_v),
		.root_o  (s2),
		.side_o  (sq3_side)
	);

	assign {x_c, y_c, c1_c} = sq2_side;
	assign {c2_c, oor_c}    = sq3_side;

	// ---------------- angles ----------------
	logic                 cv;
	logic signed [AW-1:0] phi;
	logic signed [AW-1:0] alpha;
	logic signed [AW-1:0] beta;
	logic                 oor_d [0:CORDIC_ITERATIONS];

	tlik_cordic #(
		.N (CORDIC_ITERATIONS)
	) u_cordic_phi (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq2_v && sq3_v),
		.x_i     ({{4{x_c[CW-1]}}, x_c, 8'b0}),
		.y_i     ({{4{y_c[CW-1]}}, y_c, 8'b0}),
		.valid_o (cv),
		.z_o     (phi)
	);

	tlik_cordic #(
		.N (CORDIC_ITERATIONS)
	) u_cordic_alpha (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq2_v && sq3_v),
		.x_i     ({{2{c1_c[CSW-1]}}, c1_c, 8'b0}),
		.y_i     (signed'({3'b0, s1, 8'b0})),
		.valid_o (),
		.z_o     (alpha)
	);

	tlik_cordic #(
		.N (CORDIC_ITERATIONS)
	) u_cordic_beta (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq2_v && sq3_v),
		.x_i     ({{2{c2_c[CSW-1]}}, c2_c, 8'b0}),
		.y_i     (signed'({3'b0, s2, 8'b0})),
		.valid_o (),
		.z_o     (beta)
	);

	// The out-of-reach flag rides beside the CORDICs.
	always_ff @(posedge clk) begin
		if (en) begin
			oor_d[0] <= oor_c;
		end
	end

	for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_oor
		always_ff @(posedge clk) begin
			if (en) begin
				oor_d[i+1] <= oor_d[i];
			end
		end
	end

	// ---------------- rounding, saturation, output register ----------------
	logic signed [AW:0]    sh_d;
	logic signed [AW:0]    el_d;
	logic signed [AW:0]    sh_r;
	logic signed [AW:0]    el_r;
	logic signed [16:0]    sh_sat;
	logic [14:0]           el_sat;
	logic signed [16:0]    sh_q;
	logic [14:0]           el_q;
	logic                  oor_q;

	always_comb begin
		sh_d = {phi[AW-1], phi} - {alpha[AW-1], alpha};
		el_d = {tlik_pkg::PI_Q16[AW-1], tlik_pkg::PI_Q16} - {beta[AW-1], beta};
		sh_r = (sh_d + 21'sd4) >>> 3;
		el_r = (el_d + 21'sd4) >>> 3;
		priority if (sh_r < signed'({{4{tlik_pkg::SHOULDER_MIN[16]}},
				tlik_pkg::SHOULDER_MIN})) begin
			sh_sat = tlik_pkg::SHOULDER_MIN;
		end else if (sh_r > signed'({4'b0, tlik_pkg::SHOULDER_MAX})) begin
			sh_sat = tlik_pkg::SHOULDER_MAX;
		end else begin
			sh_sat = sh_r[16:0];
		end
		priority if (el_r < 21'sd0) begin
			el_sat = '0;
		end else if (el_r > signed'({6'b0, tlik_pkg::ELBOW_MAX})) begin
			el_sat = tlik_pkg::ELBOW_MAX;
		end else begin
			el_sat = el_r[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_q <= oor_d[CORDIC_ITERATIONS];
			sh_q  <= oor_d[CORDIC_ITERATIONS] ? '0 : sh_sat;
			el_q  <= oor_d[CORDIC_ITERATIONS] ? '0 : el_sat;
		end
	end

	assign out_valid      = out_valid_q;
	assign shoulder_angle = sh_q;
	assign elbow_angle    = el_q;
	assign out_of_reach   = oor_q;

endmodule

@@ sv/tlik_checker.sv @@
// ----------------------------------------------------------------------------
// tlik_checker: port-level checks for the inverse kinematics block
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module tlik_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [16:0] shoulder_angle,
	input logic [14:0]        elbow_angle,
	input logic               out_of_reach
);

	// An unreachable target must come back with both angles cleared.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_reach |-> shoulder_angle == 17'sd0 && elbow_angle == 15'd0)
		else $error("out_of_reach result with nonzero angle");

	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> elbow_angle <= tlik_pkg::ELBOW_MAX)
		else $error("elbow angle above pi");

	// The input side may only be held off by a stalled, full output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without a pending result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(shoulder_angle)
			&& $stable(elbow_angle) && $stable(out_of_reach))
		else $error("stalled result changed");

endmodule

bind two_link_planar_inverse_kinematics tlik_checker u_tlik_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.shoulder_angle (shoulder_angle),
	.elbow_angle    (elbow_angle),
	.out_of_reach   (out_of_reach)
);
